// File: design/mslfo_pkg.sv
`default_nettype none

package mslfo_pkg;

   localparam int SINE_DEPTH_DEFAULT = 256;

   localparam int STEP_W     = 25;
   localparam int SHAPE_W    = 3;
   localparam int PHASE_W    = 32;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam int WAVE_W     = 16;

   localparam logic [STEP_W-1:0]  STEP_RESET  = 25'd97391;
   localparam logic [PHASE_W-1:0] SEED_RESET  = 32'd1;

   localparam logic [31:0] LCG_MULT = 32'd1664525;
   localparam logic [31:0] LCG_INC  = 32'd1013904223;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_STEP   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_SHAPE  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_OFFSET = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_SEED   = 2'd3;

   // shape codes
   localparam logic [SHAPE_W-1:0] SHAPE_SINE     = 3'd0;
   localparam logic [SHAPE_W-1:0] SHAPE_TRIANGLE = 3'd1;
   localparam logic [SHAPE_W-1:0] SHAPE_SAW_UP   = 3'd2;
   localparam logic [SHAPE_W-1:0] SHAPE_SAW_DOWN = 3'd3;
   localparam logic [SHAPE_W-1:0] SHAPE_SQUARE   = 3'd4;
   localparam logic [SHAPE_W-1:0] SHAPE_HOLD     = 3'd5;

   localparam logic [WAVE_W-1:0] WAVE_MAX = 16'h7fff;
   localparam logic [WAVE_W-1:0] WAVE_MIN = 16'h8000;

   // Quarter-sine entry from angle theta in Q30: order-15 Taylor series,
   // scaled to 32767 with round-half-up and clamped.
   function automatic logic [15:0] quarter_sine(input logic [63:0] theta);
      logic [63:0] t2;
      logic [63:0] term;
      longint      sum;
      logic [63:0] r;
      t2   = (theta * theta) >> 30;
      term = theta;
      sum  = longint'(theta);
      term = ((term * t2) >> 30) / 64'd6;
      sum  = sum - longint'(term);
      term = ((term * t2) >> 30) / 64'd20;
      sum  = sum + longint'(term);
      term = ((term * t2) >> 30) / 64'd42;
      sum  = sum - longint'(term);
      term = ((term * t2) >> 30) / 64'd72;
      sum  = sum + longint'(term);
      term = ((term * t2) >> 30) / 64'd110;
      sum  = sum - longint'(term);
      term = ((term * t2) >> 30) / 64'd156;
      sum  = sum + longint'(term);
      term = ((term * t2) >> 30) / 64'd210;
      sum  = sum - longint'(term);
      if (sum < 0) begin
         sum = 0;
      end
      r = (64'(sum) * 64'd32767 + 64'd536870912) >> 30;
      if (r > 64'd32767) begin
         r = 64'd32767;
      end
      return r[15:0];
   endfunction

endpackage

`default_nettype wire

// File: design/mslfo_sine_rom.sv
`default_nettype none

module mslfo_sine_rom #(
   parameter int DEPTH = mslfo_pkg::SINE_DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [15:0]   rd_data_ff
);

   logic [15:0] rom_tbl [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_tbl
      localparam logic [63:0] THETA =
         (mslfo_pkg::HALF_PI_Q30 * 64'(i)) / 64'(DEPTH);
      assign rom_tbl[i] = mslfo_pkg::quarter_sine(THETA);
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= rom_tbl[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: design/multi_shape_lfo.sv
// Low-frequency oscillator on a 32-bit phase accumulator.
// Request channel (req_*): one request per sample; req_tdata[0] set means
// restart (load the phase from phase_offset), clear means one tick (add
// phase_step). Every request yields exactly one Q1.15 sample on the
// response channel (rsp_*), the selected shape at the new phase.
// Configuration (csr_*): write phase_step, wave_shape, phase_offset and
// random_seed by index; write only while no request is in flight.
// Writing random_seed reloads the sample-and-hold generator at once.
// A request passes the phase update, the sine table read and the output
// register, in that order.
// Throughput: one request per cycle while rsp_tready is high; the sine table
// read port and the phase adder each take one request a cycle.
// Each stage moves on its own, so requests keep entering while a finished
// response waits in the output register; when the receiver stalls long
// enough to fill all three stages, req_tready drops.
// Reset clears the pipeline, zeroes the phase and held level, loads the
// generator with seed 1 and restores register defaults.
`default_nettype none

module multi_shape_lfo #(
   parameter int SINE_TABLE_DEPTH = mslfo_pkg::SINE_DEPTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [7:0]                          req_tdata,  // [0] restart
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [mslfo_pkg::WAVE_W-1:0]             rsp_tdata,  // [15:0] wave_value
   input  wire logic                                csr_wen,
   input  wire logic [mslfo_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [mslfo_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int AW = $clog2(SINE_TABLE_DEPTH);
   localparam int DW = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int PW = 30 + DW;

   // configuration
   logic [mslfo_pkg::STEP_W-1:0]  step_ff;
   logic [mslfo_pkg::SHAPE_W-1:0] shape_ff;
   logic [mslfo_pkg::PHASE_W-1:0] offset_ff;

   // oscillator state
   logic [31:0] phase_ff, phase_in;
   logic [31:0] rng_ff, rng_in;
   logic [15:0] held_ff, held_in;

   // pipeline
   logic        v1_ff, v2_ff, rsp_valid_ff;
   logic        en_out, en2, en1, accept, restart, hold_step;
   logic [32:0] phase_sum;
   logic        neg_ff, peak_ff;
   logic [15:0] alt_ff, alt_in;
   logic [15:0] rsp_data_ff, rsp_data_in;
   logic [15:0] rom_q, sine_val;

   // stage 1 address and shape values
   logic [PW-1:0] idx_prod;
   logic [AW-1:0] k_idx, rom_addr;
   logic [DW-1:0] fall_full;
   logic          peak_in;
   logic [31:0]   tri_d;
   logic [16:0]   tri_sh;

   assign en_out     = !rsp_valid_ff || rsp_tready;
   assign en2        = !v2_ff || en_out;
   assign en1        = !v1_ff || en2;
   assign req_tready = en1;
   assign accept     = req_tvalid && en1;
   assign restart    = req_tdata[0];
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= mslfo_pkg::STEP_RESET;
         shape_ff  <= mslfo_pkg::SHAPE_SINE;
         offset_ff <= '0;
      end else if (csr_wen) begin
         case (csr_addr)
            mslfo_pkg::REG_STEP:   step_ff   <= csr_wdata[mslfo_pkg::STEP_W-1:0];
            mslfo_pkg::REG_SHAPE:  shape_ff  <= csr_wdata[mslfo_pkg::SHAPE_W-1:0];
            mslfo_pkg::REG_OFFSET: offset_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // phase advance and generator step on wrap
   always_comb begin
      phase_sum = {1'b0, phase_ff} + {8'd0, step_ff};
      phase_in  = restart ? offset_ff : phase_sum[31:0];
      hold_step = accept && !restart && phase_sum[32] &&
                  (shape_ff == mslfo_pkg::SHAPE_HOLD);
      rng_in    = rng_ff * mslfo_pkg::LCG_MULT + mslfo_pkg::LCG_INC;
      held_in   = rng_in[31:16] ^ 16'h8000;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         rng_ff   <= mslfo_pkg::SEED_RESET;
         held_ff  <= '0;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
         end
         if (csr_wen && csr_addr == mslfo_pkg::REG_SEED) begin
            rng_ff <= csr_wdata;
         end else if (hold_step) begin
            rng_ff <= rng_in;
         end
         if (hold_step) begin
            held_ff <= held_in;
         end
      end
   end

   // stage 1: table address and the non-sine shapes
   always_comb begin
      idx_prod  = {{DW{1'b0}}, phase_ff[29:0]} * PW'(SINE_TABLE_DEPTH);
      k_idx     = idx_prod[30 +: AW];
      fall_full = DW'(SINE_TABLE_DEPTH) - {{(DW-AW){1'b0}}, k_idx};
      rom_addr  = phase_ff[30] ? fall_full[AW-1:0] : k_idx;
      peak_in   = phase_ff[30] && (k_idx == '0);

      tri_d  = phase_ff[31] ? {1'b0, phase_ff[30:0]} : (32'h8000_0000 - phase_ff);
      tri_sh = tri_d[31:15];

      case (shape_ff)
         mslfo_pkg::SHAPE_TRIANGLE:
            alt_in = (tri_sh == '0) ? mslfo_pkg::WAVE_MAX
                                    : 16'(17'h08000 - tri_sh);
         mslfo_pkg::SHAPE_SAW_UP:
            alt_in = {~phase_ff[31], phase_ff[30:16]};
         mslfo_pkg::SHAPE_SAW_DOWN:
            alt_in = (phase_ff[31:16] == '0) ? mslfo_pkg::WAVE_MAX
                                             : (16'h8000 - phase_ff[31:16]);
         mslfo_pkg::SHAPE_SQUARE:
            alt_in = phase_ff[31] ? mslfo_pkg::WAVE_MIN : mslfo_pkg::WAVE_MAX;
         mslfo_pkg::SHAPE_HOLD:
            alt_in = held_ff;
         default:
            alt_in = '0;
      endcase
   end

   mslfo_sine_rom #(
      .DEPTH (SINE_TABLE_DEPTH),
      .AW    (AW)
   ) u_rom (
      .clock      (clock),
      .rd_en      (en2),
      .rd_addr    (rom_addr),
      .rd_data_ff (rom_q)
   );

   always_ff @(posedge clock) begin
      if (en2) begin
         neg_ff  <= phase_ff[31];
         peak_ff <= peak_in;
         alt_ff  <= alt_in;
      end
   end

   // stage 2: sign the sine and pick the shape
   always_comb begin
      sine_val = peak_ff ? mslfo_pkg::WAVE_MAX : rom_q;
      if (shape_ff == mslfo_pkg::SHAPE_SINE) begin
         rsp_data_in = neg_ff ? (16'd0 - sine_val) : sine_val;
      end else begin
         rsp_data_in = alt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out && v2_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= req_tvalid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en_out) begin
            rsp_valid_ff <= v2_ff;
         end
      end
   end

endmodule

`default_nettype wire

// File: design/mslfo_checker.sv
`default_nettype none

module mslfo_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata
);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // an empty output register means the pipeline takes a request
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused with empty output");

   // without back-pressure, an accepted request reaches the output
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) ##1 rsp_tready ##1 rsp_tready |=> rsp_tvalid)
      else $error("response missing after request");

   // no response right after reset
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind multi_shape_lfo mslfo_checker u_mslfo_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
